>>> rtl/mpat_pkg.sv
// mpat_pkg: shared types and constants of the multiturn polar angle tracker
// no dependencies; used by every file of the block but mpat_accum

package mpat_pkg;

  localparam int ZERO_W   = 12;
  localparam int GAIN_W   = 16;
  localparam int DEG_W    = 9;
  localparam int THR_W    = 12;
  localparam int STAGE_W  = 4;
  localparam int OUT_W    = 12;
  localparam int ANGLE_W  = 22;
  localparam int FRAC_W   = 8;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ZERO_CODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_Q16       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STAGE_DEGREES  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_OFFSET   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_JUMP_THRESHOLD = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_STAGE      = 3'd5;

  localparam logic [ZERO_W-1:0]  RST_ZERO_CODE      = 12'd427;
  localparam logic [GAIN_W-1:0]  RST_GAIN_Q16       = 16'd2376;
  localparam logic [DEG_W-1:0]   RST_STAGE_DEGREES  = 9'd120;
  localparam logic [DEG_W-1:0]   RST_ANGLE_OFFSET   = 9'd55;
  localparam logic [THR_W-1:0]   RST_JUMP_THRESHOLD = 12'd2200;
  localparam logic [STAGE_W-1:0] RST_MAX_STAGE      = 4'd4;

  typedef struct packed {
    logic [ZERO_W-1:0]  zero_code;
    logic [GAIN_W-1:0]  gain_q16;
    logic [DEG_W-1:0]   stage_degrees;
    logic [DEG_W-1:0]   angle_offset;
    logic [THR_W-1:0]   jump_threshold;
    logic [STAGE_W-1:0] max_stage;
  } cfg_t;

endpackage

>>> rtl/mpat_regs.sv
// mpat_regs: apb-style configuration registers of the angle tracker
// depends on mpat_pkg for register codes, widths and reset values

module mpat_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpat_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mpat_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mpat_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mpat_pkg::cfg_t                      cfg
);

  logic [mpat_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[mpat_pkg::APB_ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_code      <= mpat_pkg::RST_ZERO_CODE;
      cfg.gain_q16       <= mpat_pkg::RST_GAIN_Q16;
      cfg.stage_degrees  <= mpat_pkg::RST_STAGE_DEGREES;
      cfg.angle_offset   <= mpat_pkg::RST_ANGLE_OFFSET;
      cfg.jump_threshold <= mpat_pkg::RST_JUMP_THRESHOLD;
      cfg.max_stage      <= mpat_pkg::RST_MAX_STAGE;
    end else if (wr) begin
      case (idx)
        mpat_pkg::REG_ZERO_CODE: begin
          cfg.zero_code <= pwdata[mpat_pkg::ZERO_W-1:0];
        end
        mpat_pkg::REG_GAIN_Q16: begin
          cfg.gain_q16 <= pwdata[mpat_pkg::GAIN_W-1:0];
        end
        mpat_pkg::REG_STAGE_DEGREES: begin
          cfg.stage_degrees <= pwdata[mpat_pkg::DEG_W-1:0];
        end
        mpat_pkg::REG_ANGLE_OFFSET: begin
          cfg.angle_offset <= pwdata[mpat_pkg::DEG_W-1:0];
        end
        mpat_pkg::REG_JUMP_THRESHOLD: begin
          cfg.jump_threshold <= pwdata[mpat_pkg::THR_W-1:0];
        end
        mpat_pkg::REG_MAX_STAGE: begin
          cfg.max_stage <= pwdata[mpat_pkg::STAGE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      mpat_pkg::REG_ZERO_CODE:      prdata = mpat_pkg::APB_DATA_W'(cfg.zero_code);
      mpat_pkg::REG_GAIN_Q16:       prdata = mpat_pkg::APB_DATA_W'(cfg.gain_q16);
      mpat_pkg::REG_STAGE_DEGREES:  prdata = mpat_pkg::APB_DATA_W'(cfg.stage_degrees);
      mpat_pkg::REG_ANGLE_OFFSET:   prdata = mpat_pkg::APB_DATA_W'(cfg.angle_offset);
      mpat_pkg::REG_JUMP_THRESHOLD: prdata = mpat_pkg::APB_DATA_W'(cfg.jump_threshold);
      mpat_pkg::REG_MAX_STAGE:      prdata = mpat_pkg::APB_DATA_W'(cfg.max_stage);
      default:                      prdata = '0;
    endcase
  end

endmodule

>>> rtl/mpat_accum.sv
// mpat_accum: sums sample groups and forms the truncated mean
// the constant divide is a reciprocal multiply plus one correction step

module mpat_accum #(
  parameter int SAMPLES_PER_AVERAGE = 5,
  parameter int SAMPLE_BITS         = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  output logic [SAMPLE_BITS-1:0] avg,
  output logic                   avg_valid,
  input  logic                   avg_stall
);

  localparam int ACC_W = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE);
  localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam int PRD_W = 2 * ACC_W + 1;
  localparam logic [ACC_W:0] RECIP =
    (ACC_W + 1)'((64'd1 << ACC_W) / SAMPLES_PER_AVERAGE);
  localparam logic [ACC_W-1:0]  DIVISOR = ACC_W'(SAMPLES_PER_AVERAGE);
  localparam logic [CNT_W-1:0]  LAST    = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  logic [ACC_W-1:0]       acc;
  logic [CNT_W-1:0]       count;
  logic                   s1_v;
  logic [ACC_W-1:0]       s1_sum;
  logic                   s2_v;
  logic [ACC_W-1:0]       s2_sum;
  logic [SAMPLE_BITS-1:0] s2_q;
  logic                   s3_v;
  logic [SAMPLE_BITS-1:0] s3_avg;

  logic                   last;
  logic                   accept;
  logic                   ready1;
  logic                   ready2;
  logic                   ready3;
  logic [ACC_W-1:0]       acc_sum;
  logic [PRD_W-1:0]       q_prod;
  logic [ACC_W-1:0]       rem;
  logic [SAMPLE_BITS-1:0] avg_next;

  assign last         = (count == LAST);
  assign ready3       = !s3_v || !avg_stall;
  assign ready2       = !s2_v || ready3;
  assign ready1       = !s1_v || ready2;
  assign sample_stall = last && !ready1;
  assign accept       = sample_valid && !sample_stall;
  assign acc_sum      = acc + ACC_W'(sample);

  assign q_prod   = PRD_W'(s1_sum) * PRD_W'(RECIP);
  assign rem      = s2_sum - ACC_W'(ACC_W'(s2_q) * DIVISOR);
  assign avg_next = s2_q + SAMPLE_BITS'(rem >= DIVISOR);

  assign avg       = s3_avg;
  assign avg_valid = s3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else if (accept) begin
      if (last) begin
        acc   <= '0;
        count <= '0;
      end else begin
        acc   <= acc_sum;
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (ready1) begin
        s1_v <= accept && last;
      end
      if (ready2) begin
        s2_v <= s1_v;
      end
      if (ready3) begin
        s3_v <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && accept && last) begin
      s1_sum <= acc_sum;
    end
    if (ready2 && s1_v) begin
      s2_sum <= s1_sum;
      s2_q   <= q_prod[ACC_W+SAMPLE_BITS-1:ACC_W];
    end
    if (ready3 && s2_v) begin
      s3_avg <= avg_next;
    end
  end

endmodule

>>> rtl/mpat_track.sv
// mpat_track: turn stage detection and running min and max of the means
// depends on mpat_pkg for the configuration struct

module mpat_track #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mpat_pkg::cfg_t                    cfg,
  input  logic [SAMPLE_BITS-1:0]            avg,
  input  logic                              avg_valid,
  output logic                              avg_stall,
  output logic                              trk_valid,
  input  logic                              trk_stall,
  output logic [SAMPLE_BITS-1:0]            trk_avg,
  output logic [mpat_pkg::STAGE_W-1:0]      trk_stage,
  output logic [SAMPLE_BITS-1:0]            trk_max,
  output logic [SAMPLE_BITS-1:0]            trk_min,
  output logic signed [((SAMPLE_BITS > mpat_pkg::ZERO_W) ? SAMPLE_BITS
                        : mpat_pkg::ZERO_W):0] trk_off
);

  localparam int CMP_W = ((SAMPLE_BITS > mpat_pkg::ZERO_W) ? SAMPLE_BITS
                          : mpat_pkg::ZERO_W) + 1;
  localparam int STEP_W = mpat_pkg::STAGE_W + 1;

  logic                    ready;
  logic                    take;
  logic [CMP_W-1:0]        a_ext;
  logic [CMP_W-1:0]        p_ext;
  logic [CMP_W-1:0]        j_ext;
  logic                    up;
  logic                    down;
  logic [STEP_W-1:0]       step;
  logic [mpat_pkg::STAGE_W-1:0] stage_next;

  assign ready     = !trk_valid || !trk_stall;
  assign avg_stall = !ready;
  assign take      = avg_valid && ready;

  // trk_avg doubles as the previous mean
  assign a_ext = CMP_W'(avg);
  assign p_ext = CMP_W'(trk_avg);
  assign j_ext = CMP_W'(cfg.jump_threshold);
  assign up    = p_ext > (a_ext + j_ext);
  assign down  = a_ext > (p_ext + j_ext);

  always_comb begin
    if (up) begin
      step = STEP_W'(trk_stage) + STEP_W'(1);
    end else if (down) begin
      step = STEP_W'(trk_stage) - STEP_W'(1);
    end else begin
      step = STEP_W'(trk_stage);
    end
    // a step below zero wraps high and falls back here too
    if (step > STEP_W'(cfg.max_stage)) begin
      stage_next = '0;
    end else begin
      stage_next = step[mpat_pkg::STAGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trk_valid <= 1'b0;
      trk_avg   <= '0;
      trk_stage <= '0;
      trk_max   <= '0;
      trk_min   <= '1;
    end else begin
      if (ready) begin
        trk_valid <= avg_valid;
      end
      if (take) begin
        trk_avg   <= avg;
        trk_stage <= stage_next;
        if (avg > trk_max) begin
          trk_max <= avg;
        end
        if (avg < trk_min) begin
          trk_min <= avg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      trk_off <= $signed(a_ext) - $signed(CMP_W'(cfg.zero_code));
    end
  end

endmodule

>>> rtl/mpat_angle.sv
// mpat_angle: q8 angle from stage and mean, with rounding and saturation
// depends on mpat_pkg for the configuration struct and output widths

module mpat_angle #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mpat_pkg::cfg_t                    cfg,
  input  logic                              trk_valid,
  output logic                              trk_stall,
  input  logic [SAMPLE_BITS-1:0]            trk_avg,
  input  logic [mpat_pkg::STAGE_W-1:0]      trk_stage,
  input  logic [SAMPLE_BITS-1:0]            trk_max,
  input  logic [SAMPLE_BITS-1:0]            trk_min,
  input  logic signed [((SAMPLE_BITS > mpat_pkg::ZERO_W) ? SAMPLE_BITS
                       : mpat_pkg::ZERO_W):0] trk_off,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [mpat_pkg::ANGLE_W-1:0] angle_q8,
  output logic [mpat_pkg::STAGE_W-1:0]      stage,
  output logic [mpat_pkg::OUT_W-1:0]        average,
  output logic [mpat_pkg::OUT_W-1:0]        max_seen,
  output logic [mpat_pkg::OUT_W-1:0]        min_seen
);

  localparam int DIFF_W = ((SAMPLE_BITS > mpat_pkg::ZERO_W) ? SAMPLE_BITS
                           : mpat_pkg::ZERO_W) + 1;
  localparam int PROD_W = mpat_pkg::GAIN_W + 1 + DIFF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int STM_W  = mpat_pkg::STAGE_W + mpat_pkg::DEG_W;
  localparam logic signed [SUM_W-1:0] ANG_HI = SUM_W'((2 ** (mpat_pkg::ANGLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] ANG_LO = -SUM_W'(2 ** (mpat_pkg::ANGLE_W - 1));
  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(2 ** (mpat_pkg::FRAC_W - 1));

  logic                          a1_v;
  logic signed [PROD_W-1:0]      a1_prod;
  logic [STM_W-1:0]              a1_sterm;
  logic [SAMPLE_BITS-1:0]        a1_avg;
  logic [mpat_pkg::STAGE_W-1:0]  a1_stage;
  logic [SAMPLE_BITS-1:0]        a1_max;
  logic [SAMPLE_BITS-1:0]        a1_min;

  logic                          ready1;
  logic                          ready2;
  logic signed [SUM_W-1:0]       gain_term;
  logic signed [SUM_W-1:0]       stage_term;
  logic signed [SUM_W-1:0]       offset_term;
  logic signed [SUM_W-1:0]       sum;
  logic signed [mpat_pkg::ANGLE_W-1:0] angle_next;

  assign ready2    = !result_valid || !result_stall;
  assign ready1    = !a1_v || ready2;
  assign trk_stall = !ready1;

  // round to nearest, ties up, is floor of (prod + half) / 256
  assign gain_term   = (SUM_W'(a1_prod) + HALF) >>> mpat_pkg::FRAC_W;
  assign stage_term  = $signed(SUM_W'({a1_sterm, {mpat_pkg::FRAC_W{1'b0}}}));
  assign offset_term = $signed(SUM_W'({cfg.angle_offset, {mpat_pkg::FRAC_W{1'b0}}}));
  assign sum         = stage_term + gain_term - offset_term;

  always_comb begin
    if (sum > ANG_HI) begin
      angle_next = ANG_HI[mpat_pkg::ANGLE_W-1:0];
    end else if (sum < ANG_LO) begin
      angle_next = ANG_LO[mpat_pkg::ANGLE_W-1:0];
    end else begin
      angle_next = sum[mpat_pkg::ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1) begin
        a1_v <= trk_valid;
      end
      if (ready2) begin
        result_valid <= a1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && trk_valid) begin
      a1_prod  <= $signed({1'b0, cfg.gain_q16}) * trk_off;
      a1_sterm <= STM_W'(trk_stage) * STM_W'(cfg.stage_degrees);
      a1_avg   <= trk_avg;
      a1_stage <= trk_stage;
      a1_max   <= trk_max;
      a1_min   <= trk_min;
    end
    if (ready2 && a1_v) begin
      angle_q8 <= angle_next;
      stage    <= a1_stage;
      average  <= mpat_pkg::OUT_W'(a1_avg);
      max_seen <= mpat_pkg::OUT_W'(a1_max);
      min_seen <= mpat_pkg::OUT_W'(a1_min);
    end
  end

endmodule

>>> rtl/multiturn_polar_angle_tracker.sv
// multiturn_polar_angle_tracker: top level of the polarization angle tracker
// depends on mpat_pkg, mpat_regs, mpat_accum, mpat_track and mpat_angle

// One sample is accepted every clock unless sample_stall is high. Each group
// of SAMPLES_PER_AVERAGE samples gives one result item carrying the truncated
// mean, the running min and max of the means, the turn stage and a signed Q8
// angle; other samples give nothing. The sample completing a group passes
// through three stages that form the mean (sum, reciprocal multiply,
// correction), one that updates the stage and min/max state, and two that
// form the angle (gain multiply, then round, add and saturate).
// Every stage holds its item independently, so samples keep flowing while a
// result waits on result_stall, up to the point where the pipeline is full.
// Registers sit at byte addresses 4*i and should be written only while the
// block is idle.

module multiturn_polar_angle_tracker #(
  parameter int SAMPLES_PER_AVERAGE = 5,
  parameter int SAMPLE_BITS         = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mpat_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [mpat_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [mpat_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  input  logic [SAMPLE_BITS-1:0]                sample,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  output logic signed [mpat_pkg::ANGLE_W-1:0]   angle_q8,
  output logic [mpat_pkg::STAGE_W-1:0]          stage,
  output logic [mpat_pkg::OUT_W-1:0]            average,
  output logic [mpat_pkg::OUT_W-1:0]            max_seen,
  output logic [mpat_pkg::OUT_W-1:0]            min_seen,
  output logic                                  result_valid,
  input  logic                                  result_stall
);

  localparam int DIFF_W = ((SAMPLE_BITS > mpat_pkg::ZERO_W) ? SAMPLE_BITS
                           : mpat_pkg::ZERO_W) + 1;

  mpat_pkg::cfg_t                cfg;
  logic [SAMPLE_BITS-1:0]        avg;
  logic                          avg_valid;
  logic                          avg_stall;
  logic                          trk_valid;
  logic                          trk_stall;
  logic [SAMPLE_BITS-1:0]        trk_avg;
  logic [mpat_pkg::STAGE_W-1:0]  trk_stage;
  logic [SAMPLE_BITS-1:0]        trk_max;
  logic [SAMPLE_BITS-1:0]        trk_min;
  logic signed [DIFF_W-1:0]      trk_off;

  mpat_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpat_accum #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .SAMPLE_BITS         (SAMPLE_BITS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .avg          (avg),
    .avg_valid    (avg_valid),
    .avg_stall    (avg_stall)
  );

  mpat_track #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .avg       (avg),
    .avg_valid (avg_valid),
    .avg_stall (avg_stall),
    .trk_valid (trk_valid),
    .trk_stall (trk_stall),
    .trk_avg   (trk_avg),
    .trk_stage (trk_stage),
    .trk_max   (trk_max),
    .trk_min   (trk_min),
    .trk_off   (trk_off)
  );

  mpat_angle #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_angle (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .trk_valid    (trk_valid),
    .trk_stall    (trk_stall),
    .trk_avg      (trk_avg),
    .trk_stage    (trk_stage),
    .trk_max      (trk_max),
    .trk_min      (trk_min),
    .trk_off      (trk_off),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .angle_q8     (angle_q8),
    .stage        (stage),
    .average      (average),
    .max_seen     (max_seen),
    .min_seen     (min_seen)
  );

endmodule

>>> tb/sv/mpat_result_checker.sv
`timescale 1ns / 1ps
// mpat_result_checker: follows register writes and both item channels of the
// angle tracker, predicts each result item and compares it field by field
// depends on mpat_pkg for widths, register indexes and reset values

module mpat_result_checker #(
  parameter int GROUP_SIZE  = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [mpat_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mpat_pkg::APB_DATA_W-1:0]     pwdata,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic                                sample_valid,
  input  logic                                sample_stall,
  input  logic signed [mpat_pkg::ANGLE_W-1:0] angle_q8,
  input  logic [mpat_pkg::STAGE_W-1:0]        stage,
  input  logic [mpat_pkg::OUT_W-1:0]          average,
  input  logic [mpat_pkg::OUT_W-1:0]          max_seen,
  input  logic [mpat_pkg::OUT_W-1:0]          min_seen,
  input  logic                                result_valid,
  input  logic                                result_stall,
  output int                                  fail_count,
  output int                                  pending
);
  import mpat_pkg::*;

  localparam longint ANGLE_HI = (longint'(1) << (ANGLE_W - 1)) - 1;
  localparam longint ANGLE_LO = -(longint'(1) << (ANGLE_W - 1));

  typedef struct {
    logic signed [ANGLE_W-1:0] angle_q8;
    logic [STAGE_W-1:0]        stage;
    logic [OUT_W-1:0]          average;
    logic [OUT_W-1:0]          max_seen;
    logic [OUT_W-1:0]          min_seen;
  } angle_result_t;

  cfg_t               shadow;
  logic [15:0]        group_sum;
  int unsigned        group_fill;
  logic [OUT_W-1:0]   last_mean;
  logic [STAGE_W-1:0] turn_stage;
  logic [OUT_W-1:0]   mean_hi;
  logic [OUT_W-1:0]   mean_lo;
  angle_result_t      predicted_results[$];
  int                 errors = 0;

  // accumulate one sample; a completed group yields one predicted result
  task automatic fold_sample(input logic [SAMPLE_BITS-1:0] s);
    logic [OUT_W-1:0] mean;
    int               diff;
    int               next_stage;
    longint           prod;
    longint           angle;
    angle_result_t    r;
    group_sum  = group_sum + 16'(s);
    group_fill = group_fill + 1;
    if (group_fill == GROUP_SIZE) begin
      mean       = OUT_W'(group_sum / GROUP_SIZE);
      group_sum  = '0;
      group_fill = 0;
      if (mean > mean_hi) mean_hi = mean;
      if (mean < mean_lo) mean_lo = mean;
      diff       = int'(mean) - int'(last_mean);
      next_stage = int'(turn_stage);
      if (diff < -int'(shadow.jump_threshold)) next_stage++;
      if (diff > int'(shadow.jump_threshold)) next_stage--;
      if (next_stage < 0 || next_stage > int'(shadow.max_stage)) next_stage = 0;
      turn_stage = STAGE_W'(next_stage);
      last_mean  = mean;
      prod  = longint'(shadow.gain_q16) * (longint'(mean) - longint'(shadow.zero_code));
      // q16 to q8, round half up
      angle = longint'(next_stage) * longint'(shadow.stage_degrees) * 256
            + ((prod + 128) >>> 8)
            - longint'(shadow.angle_offset) * 256;
      if (angle > ANGLE_HI) angle = ANGLE_HI;
      if (angle < ANGLE_LO) angle = ANGLE_LO;
      r.angle_q8 = angle[ANGLE_W-1:0];
      r.stage    = turn_stage;
      r.average  = mean;
      r.max_seen = mean_hi;
      r.min_seen = mean_lo;
      predicted_results.push_back(r);
    end
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    angle_result_t    want;
    logic [REG_IDX_W-1:0] idx;
    if (rst) begin
      shadow.zero_code      = RST_ZERO_CODE;
      shadow.gain_q16       = RST_GAIN_Q16;
      shadow.stage_degrees  = RST_STAGE_DEGREES;
      shadow.angle_offset   = RST_ANGLE_OFFSET;
      shadow.jump_threshold = RST_JUMP_THRESHOLD;
      shadow.max_stage      = RST_MAX_STAGE;
      group_sum  = '0;
      group_fill = 0;
      last_mean  = '0;
      turn_stage = '0;
      mean_hi    = '0;
      mean_lo    = '1;
      predicted_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[2 +: REG_IDX_W];
        case (idx)
          REG_ZERO_CODE:      shadow.zero_code      = pwdata[ZERO_W-1:0];
          REG_GAIN_Q16:       shadow.gain_q16       = pwdata[GAIN_W-1:0];
          REG_STAGE_DEGREES:  shadow.stage_degrees  = pwdata[DEG_W-1:0];
          REG_ANGLE_OFFSET:   shadow.angle_offset   = pwdata[DEG_W-1:0];
          REG_JUMP_THRESHOLD: shadow.jump_threshold = pwdata[THR_W-1:0];
          REG_MAX_STAGE:      shadow.max_stage      = pwdata[STAGE_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result item expected none actual average %0d", $time, average);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          report_field("angle_q8", want.angle_q8, angle_q8);
          report_field("stage", want.stage, stage);
          report_field("average", want.average, average);
          report_field("max_seen", want.max_seen, max_seen);
          report_field("min_seen", want.min_seen, min_seen);
        end
      end
      if (sample_valid && !sample_stall) fold_sample(sample);
    end
    pending    <= predicted_results.size();
    fail_count <= errors;
  end

endmodule

>>> tb/sv/tb_multiturn_polar_angle_tracker.sv
`timescale 1ns / 1ps
// tb_multiturn_polar_angle_tracker: drives register writes and sample items
// into the angle tracker with random gaps and stalls, and gives the verdict
// depends on mpat_pkg, multiturn_polar_angle_tracker and mpat_result_checker

module tb_multiturn_polar_angle_tracker;
  import mpat_pkg::*;

  localparam int GROUP_SIZE   = 5;
  localparam int SAMPLE_BITS  = 12;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1600;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [SAMPLE_BITS-1:0] DIRECTED_SAMPLES [25] = '{
    12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd0,    12'd0,    12'd0,    12'd0,    12'd4,
    12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4094,
    12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2051
  };

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0]         paddr        = '0;
  logic [APB_DATA_W-1:0]         pwdata       = '0;
  logic [APB_DATA_W-1:0]         prdata;
  logic                          pready;
  logic [SAMPLE_BITS-1:0]        sample       = '0;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  logic signed [ANGLE_W-1:0]     angle_q8;
  logic [STAGE_W-1:0]            stage;
  logic [OUT_W-1:0]              average;
  logic [OUT_W-1:0]              max_seen;
  logic [OUT_W-1:0]              min_seen;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  int                            fail_count;
  int                            pending;

  int sent_total = 0;
  int burst_left = 0;
  int level      = 0;
  int step       = 1;
  int jitter     = 0;
  bit forward    = 1'b1;

  multiturn_polar_angle_tracker #(
    .SAMPLES_PER_AVERAGE(GROUP_SIZE),
    .SAMPLE_BITS        (SAMPLE_BITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .sample      (sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .angle_q8    (angle_q8),
    .stage       (stage),
    .average     (average),
    .max_seen    (max_seen),
    .min_seen    (min_seen),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

  mpat_result_checker #(
    .GROUP_SIZE (GROUP_SIZE),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .sample      (sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .angle_q8    (angle_q8),
    .stage       (stage),
    .average     (average),
    .max_seen    (max_seen),
    .min_seen    (min_seen),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver stall pattern, changes character after each run of random length
  initial begin : stall_pattern
    int mode;
    int run;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(20, 200);
      repeat (run) begin
        @(negedge clk);
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 1) == 1);
          2:       result_stall <= ($urandom_range(0, 7) == 0);
          default: result_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sent_total++;
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper bits beyond the register width are random
  function automatic logic [APB_DATA_W-1:0] with_junk(input logic [APB_DATA_W-1:0] value,
                                                      input int width);
    return ($urandom & ~((32'h1 << width) - 1)) | value;
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_field(input int width);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return (32'h1 << width) - 1;
      default: return $urandom_range(0, (1 << width) - 1);
    endcase
  endfunction

  task automatic write_config(input cfg_t c);
    apb_write(REG_ZERO_CODE,      with_junk(32'(c.zero_code), ZERO_W));
    apb_write(REG_GAIN_Q16,       with_junk(32'(c.gain_q16), GAIN_W));
    apb_write(REG_STAGE_DEGREES,  with_junk(32'(c.stage_degrees), DEG_W));
    apb_write(REG_ANGLE_OFFSET,   with_junk(32'(c.angle_offset), DEG_W));
    apb_write(REG_JUMP_THRESHOLD, with_junk(32'(c.jump_threshold), THR_W));
    apb_write(REG_MAX_STAGE,      with_junk(32'(c.max_stage), STAGE_W));
  endtask

  // stop sending and wait until every predicted result has arrived
  task automatic drain_results();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one group around the current pot level, then the level moves and wraps
  task automatic send_tracking_group();
    int v;
    repeat (GROUP_SIZE) begin
      v = level + int'($urandom_range(0, 2 * jitter)) - jitter;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      send_sample(SAMPLE_BITS'(v));
    end
    level = forward ? level + step : level - step;
    if (level > SAMPLE_MAX) level -= SAMPLE_MAX + 1;
    if (level < 0) level += SAMPLE_MAX + 1;
  endtask

  initial begin : stimulus
    cfg_t c;
    int   groups;
    int   step_hi;
    int   pick;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset settings: extremes, fallback below zero, truncation
    foreach (DIRECTED_SAMPLES[i]) send_sample(DIRECTED_SAMPLES[i]);
    drain_results();

    // steep gain, wide stages: climbs past max stage and saturates the angle
    c = '{zero_code: '0, gain_q16: '1, stage_degrees: '1, angle_offset: '0,
          jump_threshold: 12'd1000, max_stage: 4'd15};
    write_config(c);
    apb_write(REG_SPARE_LO, $urandom);
    apb_write(REG_SPARE_HI, $urandom);
    forward = 1'b1;
    level   = 0;
    step    = 900;
    jitter  = 2;
    repeat (90) send_tracking_group();
    drain_results();

    // rounding ties, zero threshold, max stage lowered below the held stage
    c = '{zero_code: 12'd2048, gain_q16: 16'd128, stage_degrees: '0, angle_offset: '1,
          jump_threshold: '0, max_stage: '0};
    write_config(c);
    forward = 1'b0;
    level   = 2060;
    step    = 1;
    jitter  = 0;
    repeat (20) send_tracking_group();
    drain_results();

    while (sent_total < RANDOM_ITEMS) begin
      c.zero_code      = ZERO_W'(pick_field(ZERO_W));
      c.gain_q16       = GAIN_W'(pick_field(GAIN_W));
      c.stage_degrees  = DEG_W'(pick_field(DEG_W));
      c.angle_offset   = DEG_W'(pick_field(DEG_W));
      c.jump_threshold = THR_W'(pick_field(THR_W));
      c.max_stage      = STAGE_W'(pick_field(STAGE_W));
      write_config(c);
      // a group split by the register writes is finished first
      while (sent_total % GROUP_SIZE != 0)
        send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
      step_hi = int'(c.jump_threshold);
      if (SAMPLE_MAX - step_hi < step_hi) step_hi = SAMPLE_MAX - step_hi;
      if (step_hi < 1) step_hi = 1;
      step    = $urandom_range(1, step_hi);
      jitter  = $urandom_range(0, 4);
      forward = 1'($urandom_range(0, 1));
      groups  = $urandom_range(10, 40);
      repeat (groups) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0, 1: repeat (GROUP_SIZE) send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
          2: begin
            pick = $urandom_range(0, 2);
            repeat (GROUP_SIZE) begin
              if (pick == 2) send_sample(SAMPLE_BITS'($urandom_range(0, 1) ? SAMPLE_MAX : 0));
              else send_sample(SAMPLE_BITS'(pick == 1 ? SAMPLE_MAX : 0));
            end
          end
          3: begin
            forward = !forward;
            send_tracking_group();
          end
          default: send_tracking_group();
        endcase
      end
      repeat ($urandom_range(0, GROUP_SIZE - 1))
        send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
      drain_results();
    end

    drain_results();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
